// ===== hdl/qdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types and constants for the converter event word decoder.
// ----------------------------------------------------------------------------
package qdc_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int CH_W         = 6;
	localparam int BRD_CH_W     = 5;
	localparam int VALUE_W      = 12;
	localparam int GATE_W       = 32;
	localparam int WORD_W       = 32;
	localparam int LIMIT_W      = 24;
	localparam int MASK_W       = 64;
	localparam int OUT_TDATA_W  = 56;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;
	localparam int FIFO_CW      = 3;

	localparam logic [1:0] CMD_DATA  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] KIND_DATA   = 3'd0;
	localparam logic [2:0] KIND_HEADER = 3'd2;
	localparam logic [2:0] KIND_EOB    = 3'd4;

	localparam logic [WORD_W-1:0] STOP_WORD = 32'hFFFF_FFFF;

	localparam logic REG_MASK  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd1024;

	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] addr;
	} hit_wr_t;

	typedef struct packed {
		logic [VALUE_W-1:0] adc_value;
		logic [CH_W-1:0]    channel;
		logic [GATE_W-1:0]  gate_count;
	} out_item_t;

endpackage

// ===== hdl/qdc_event_word_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_event_word_decoder
// Decodes converter buffer words into gated channel samples, with one shared
// sample limit checked against per-channel saturating counters.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// s_axis  | in        | tvalid/tready      | tdata: data_word; tuser: command, board
// m_axis  | out       | tvalid/tready      | tdata: gate_count, channel, adc_value
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while the output buffer has room. A word passes
// through the hit counter memory read and then the compare and write-back.
// Same-channel words back to back are served by a forwarding path.
// Reset clears section state, gate counters and hit counter valid bits at once.
// Results queue in a four-entry output buffer; input stalls once the buffered
// results plus a sample still in its compare cycle reach four.
// ----------------------------------------------------------------------------
module qdc_event_word_decoder
	import qdc_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [WORD_W-1:0]      s_axis_tdata,  // [31:0] data_word
	input  logic [2:0]             s_axis_tuser,  // [1:0] command, [2] board
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] gate_count, [37:32] channel,
	                                              // [49:38] adc_value, [55:50] zero
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [MASK_W-1:0]      cfg_data
);

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic [MASK_W-1:0]  mask_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               in_section_q;
	logic               stopped_q;
	logic [GATE_W-1:0]  gates_q [2];

	logic               s_acc;
	logic [1:0]         cmd;
	logic               bd;
	logic [2:0]         kind;
	logic [CH_W-1:0]    ch;
	logic               is_data;
	logic               cand;

	logic               valid_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [GATE_W-1:0]  gate_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               flag_s1;

	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic                   emit;
	hit_wr_t                hit_wr;

	out_item_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] fill_q;
	logic               pop;

	assign cfg_ready = 1'b1;

	assign cmd  = s_axis_tuser[1:0];
	assign bd   = s_axis_tuser[2];
	assign kind = s_axis_tdata[26:24];
	assign ch   = {bd, s_axis_tdata[20:16]};

	assign s_axis_tready = (fill_q + {{(FIFO_CW-1){1'b0}}, valid_s1})
		<= FIFO_CW'(FIFO_DEPTH - 1);
	assign s_acc = s_axis_tvalid && s_axis_tready;

	assign is_data = (cmd == CMD_DATA) && !stopped_q && (s_axis_tdata != STOP_WORD);
	assign cand    = is_data && in_section_q && (kind == KIND_DATA) && mask_q[ch];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MASK:  mask_q  <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default:   mask_q  <= mask_q;
			endcase
		end
	end

	// section tracking and gate counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_section_q <= 1'b0;
			stopped_q    <= 1'b0;
			gates_q[0]   <= '0;
			gates_q[1]   <= '0;
		end else if (s_acc) begin
			priority case (cmd)
				CMD_START: begin
					in_section_q <= 1'b0;
					stopped_q    <= 1'b0;
				end
				CMD_CLEAR: begin
					gates_q[0] <= '0;
					gates_q[1] <= '0;
				end
				CMD_DATA: begin
					if (!stopped_q) begin
						if (s_axis_tdata == STOP_WORD) begin
							stopped_q <= 1'b1;
						end else if (!in_section_q) begin
							if (kind == KIND_HEADER) begin
								in_section_q <= 1'b1;
								if (gates_q[bd] != '1) begin
									gates_q[bd] <= gates_q[bd] + 1'b1;
								end
							end
						end else if (kind == KIND_EOB) begin
							in_section_q <= 1'b0;
						end
					end
				end
				default: in_section_q <= in_section_q;
			endcase
		end
	end

	// stage 1: counter read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_acc && cand;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_s1    <= ch;
			gate_s1  <= gates_q[bd];
			value_s1 <= s_axis_tdata[VALUE_W-1:0];
			flag_s1  <= |s_axis_tdata[13:12];
		end
	end

	qdc_hit_mem #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_hit_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (s_acc),
		.rd_addr  (ch),
		.clear    (s_acc && (cmd == CMD_CLEAR)),
		.wr       (hit_wr),
		.wr_data  (cnt_next),
		.rd_count (cnt)
	);

	assign emit = valid_s1 && !flag_s1
		&& (CMP_W'(cnt) < CMP_W'(limit_q));
	assign cnt_next = (cnt == '1) ? cnt : cnt + 1'b1;
	assign hit_wr.en   = emit;
	assign hit_wr.addr = ch_s1;

	// output buffer
	assign pop = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (fill_q != '0);
	assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, fifo_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (emit) begin
			fifo_q[wr_ptr_q] <= '{adc_value: value_s1, channel: ch_s1, gate_count: gate_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (emit) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({emit, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hdl/qdc_hit_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_hit_mem
// Per-channel hit counter memory: registered read, write-back with
// forwarding, per-entry valid bits so that a clear empties all entries at once.
// ----------------------------------------------------------------------------
module qdc_hit_mem
	import qdc_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [CH_W-1:0]        rd_addr,
	input  logic                   clear,
	input  hit_wr_t                wr,
	input  logic [COUNT_WIDTH-1:0] wr_data,
	output logic [COUNT_WIDTH-1:0] rd_count
);

	logic [COUNT_WIDTH-1:0]  mem [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0]  rd_data_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic                    vld_s1;
	logic                    fwd_s1;
	logic [COUNT_WIDTH-1:0]  fwd_data_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q   <= mem[rd_addr];
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				fwd_s1 <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	assign rd_count = fwd_s1 ? fwd_data_s1 : (vld_s1 ? rd_data_q : '0);

endmodule
